// File: rtl/spq_pkg.sv
// spq_pkg: shared types and constants of the sorted priority task queue
// used by spq_ctrl, spq_datapath and sorted_priority_task_queue; no dependencies
package spq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 7;
    localparam int PRIO_W      = 8;
    localparam int WORD_W      = 64;

    // operation codes of an input beat
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_POPPED   = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic                opcode;
        logic [PRIO_W-1:0]   task_priority;
        logic [WORD_W-1:0]   handler_handle;
        logic [WORD_W-1:0]   handler_argument;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [PRIO_W-1:0]   out_priority;
        logic [WORD_W-1:0]   out_handler;
        logic [WORD_W-1:0]   out_argument;
        logic [OCC_W-1:0]    occupancy;
    } t_out_item;

    // one stored queue entry
    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [WORD_W-1:0]   handler;
        logic [WORD_W-1:0]   argument;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// File: rtl/spq_ctrl.sv
// spq_ctrl: handshake controller of the sorted priority task queue
// depends on spq_pkg; drives command beats into spq_datapath
module spq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output spq_pkg::t_dp_cmd o_cmd
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   can_exec;

    // accept only in idle; execute once the output register is free
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign can_exec = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_exec) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output beat valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (can_exec) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = accept;
    assign o_cmd.exec  = can_exec;

`ifndef ASSERT_OFF
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted beat did not move to execute");
    a_exec_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        can_exec |=> r_out_valid)
        else $error("executed beat did not raise output valid");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !can_exec)
        else $error("pending result overwritten");
`endif

endmodule

// File: rtl/spq_datapath.sv
// spq_datapath: sorted shift-register cell array, input and result registers
// depends on spq_pkg; commanded by spq_ctrl
module spq_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_dp_cmd   i_cmd,
    input  spq_pkg::t_in_item  i_item,
    output spq_pkg::t_out_item o_result
);
    import spq_pkg::*;

    t_in_item                r_item;
    t_out_item               r_result;
    t_entry                  r_entry [QUEUE_DEPTH];
    logic [CNT_W-1:0]        r_count, n_count;
    logic [QUEUE_DEPTH-1:0]  gt;
    logic                    full;
    logic                    empty;
    t_entry                  new_entry;

    assign full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty = (r_count == '0);
    assign new_entry = '{prio:     r_item.task_priority,
                         handler:  r_item.handler_handle,
                         argument: r_item.handler_argument};

    // per-cell compare against the incoming priority
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            gt[i] = (CNT_W'(i) < r_count) && (r_entry[i].prio > r_item.task_priority);
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // cell array: shift up from the insert point, or shift down on pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_item.opcode == OP_INSERT) begin
                if (!full) begin
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        if ((CNT_W'(i) == r_count) || gt[i]) begin
                            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                                r_entry[i] <= r_entry[(i > 0) ? i - 1 : 0];
                            end else begin
                                r_entry[i] <= new_entry;
                            end
                        end
                    end
                end
            end else if (!empty) begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                    r_entry[i] <= r_entry[i + 1];
                end
            end
        end
    end

    // entry count update
    always_comb begin
        n_count = r_count;
        if (i_cmd.exec) begin
            if (r_item.opcode == OP_INSERT) begin
                if (!full) begin
                    n_count = r_count + CNT_W'(1);
                end
            end else if (!empty) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_result.out_priority <= '0;
            r_result.out_handler  <= '0;
            r_result.out_argument <= '0;
            r_result.occupancy    <= OCC_W'(n_count);
            if (r_item.opcode == OP_INSERT) begin
                r_result.status <= full ? ST_DROPPED : ST_INSERTED;
            end else if (empty) begin
                r_result.status <= ST_EMPTY;
            end else begin
                r_result.status       <= ST_POPPED;
                r_result.out_priority <= r_entry[0].prio;
                r_result.out_handler  <= r_entry[0].handler;
                r_result.out_argument <= r_entry[0].argument;
            end
        end
    end

    assign o_result = r_result;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (r_entry[0].prio <= r_entry[1].prio))
        else $error("head entries out of order");
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_item.opcode == OP_INSERT) && !full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the queue");
`endif

endmodule

// File: rtl/sorted_priority_task_queue.sv
// sorted_priority_task_queue: fixed-depth task queue kept sorted by priority
// an accepted input beat is captured in the input register, then, once the
// output register is free, executed into the result register; no new beat is
// accepted until then; the cell array inserts or pops in one parallel update
// reset: synchronous active low, clears entry count and handshake state;
// entry contents stay undefined until written, no clearing pass
module sorted_priority_task_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spq_pkg::t_out_item o_out_data
);
    import spq_pkg::*;

    t_dp_cmd cmd;

    // handshake controller
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // sorted cell array and result register
    spq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_in_data),
        .o_result (o_out_data)
    );

endmodule
